@@ hw/rtl/tibq_pkg.sv @@
// Shared types and constants for the TLB invalidate batch queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tibq_pkg;

    // Depth of the batched page-invalidation store
    localparam int QUEUE_DEPTH = 4;

    localparam int ROOT_W = 40;
    localparam int ADDR_W = 48;

    // Store index, and a count that also holds the overflow mark (QUEUE_DEPTH+1)
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 2);

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_OVFL = CNT_W'(QUEUE_DEPTH + 1);

    // Request codes
    localparam logic FUNC_QUEUE  = 1'b0;
    localparam logic FUNC_SWITCH = 1'b1;

    // Result codes
    localparam logic ACT_PAGE  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // One result word
    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] inval_addr;
        logic [ROOT_W-1:0] flush_root;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/tlb_invalidate_batch_queue_core.sv @@
// Result words reach m_ from the registers of the two-entry result queue.
// Requests are taken only while no replay runs and the queue has room; a switch starts
// the single-word replay, one page (up to QUEUE_DEPTH) per cycle while room is left.
// The two-entry result queue lets requests keep flowing while m_ stalls, until it fills.
// Reset (aresetn, synchronous, low) clears root, batch count and the result queue;
// the page store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module tlb_invalidate_batch_queue_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_func,
    input  wire logic [tibq_pkg::ROOT_W-1:0]  s_table_root,
    input  wire logic [tibq_pkg::ADDR_W-1:0]  s_page_addr,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_action,
    output logic [tibq_pkg::ADDR_W-1:0]       m_inval_addr,
    output logic [tibq_pkg::ROOT_W-1:0]       m_flush_root,
    output logic                              m_last
);
    import tibq_pkg::*;

    logic    push_valid, push_ready;
    result_t push_word, pop_word;

    // Front end: classify and sequence
    tibq_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_table_root (s_table_root),
        .s_page_addr  (s_page_addr),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_word    (push_word)
    );

    // Back end: result word queue driving the output
    tibq_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (m_valid),
        .pop_ready  (m_ready),
        .pop_word   (pop_word)
    );

    assign m_action     = pop_word.action;
    assign m_inval_addr = pop_word.inval_addr;
    assign m_flush_root = pop_word.flush_root;
    assign m_last       = pop_word.last;

endmodule

`default_nettype wire

@@ hw/rtl/tibq_fifo.sv @@
// Two-entry result word queue between the front end and the output port.
// Depends on tibq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tibq_fifo (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire tibq_pkg::result_t push_word,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output tibq_pkg::result_t     pop_word
);
    import tibq_pkg::*;

    result_t    mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_word   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Word storage, no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'd2)
        else $error("fifo occupancy out of range");
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("fifo pointers disagree with occupancy");
    a_head_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_valid && !pop_ready) |=> (pop_valid && $stable(pop_word)))
        else $error("queued word changed while stalled");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/tibq_front.sv @@
// Front end: takes requests, keeps the current root and the page store,
// and turns each switch into result words for the queue. Depends on tibq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tibq_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_func,
    input  wire logic [tibq_pkg::ROOT_W-1:0]  s_table_root,
    input  wire logic [tibq_pkg::ADDR_W-1:0]  s_page_addr,
    output logic                              push_valid,
    input  wire logic                         push_ready,
    output tibq_pkg::result_t                 push_word
);
    import tibq_pkg::*;

    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] last_addr_reg, last_addr_next;
    logic [ADDR_W-1:0] store [QUEUE_DEPTH];
    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  rcnt_reg, rcnt_next;

    logic accept, root_hit, store_wr, replay_push, replay_last;

    assign s_ready  = !busy_reg && push_ready;
    assign accept   = s_valid && s_ready;
    assign root_hit = (s_table_root == root_reg);
    assign replay_push = busy_reg && push_ready;
    assign replay_last = (CNT_W'(idx_reg + CNT_W'(1)) == rcnt_reg);

    // Classify the request and update the batch state
    always_comb begin
        root_next      = root_reg;
        count_next     = count_reg;
        last_addr_next = last_addr_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        rcnt_next      = rcnt_reg;
        store_wr       = 1'b0;
        push_valid     = 1'b0;
        push_word      = '0;

        if (busy_reg) begin
            // Replay one stored page per free queue slot
            push_valid           = 1'b1;
            push_word.action     = ACT_PAGE;
            push_word.inval_addr = store[idx_reg[IDX_W-1:0]];
            push_word.last       = replay_last;
            if (replay_push) begin
                idx_next = CNT_W'(idx_reg + CNT_W'(1));
                if (replay_last) begin
                    busy_next = 1'b0;
                end
            end
        end else if (accept) begin
            if (s_func == FUNC_QUEUE) begin
                if (root_hit) begin
                    priority if (count_reg >= CNT_FULL) begin
                        count_next = CNT_OVFL;
                    end else if (count_reg != '0 && last_addr_reg == s_page_addr) begin
                        count_next = count_reg;
                    end else begin
                        store_wr       = 1'b1;
                        last_addr_next = s_page_addr;
                        count_next     = CNT_W'(count_reg + CNT_W'(1));
                    end
                end
            end else begin
                if (!root_hit || count_reg == CNT_OVFL) begin
                    // Root change or lost pages: one full flush
                    push_valid           = 1'b1;
                    push_word.action     = ACT_FLUSH;
                    push_word.flush_root = s_table_root;
                    push_word.last       = 1'b1;
                end else if (count_reg != '0) begin
                    busy_next = 1'b1;
                    idx_next  = '0;
                    rcnt_next = count_reg;
                end
                root_next  = s_table_root;
                count_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg  <= '0;
            count_reg <= '0;
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            rcnt_reg  <= '0;
        end else begin
            root_reg  <= root_next;
            count_reg <= count_next;
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            rcnt_reg  <= rcnt_next;
        end
    end

    // Page store and last-queued address, no reset
    always_ff @(posedge aclk) begin
        last_addr_reg <= last_addr_next;
        if (store_wr) begin
            store[count_reg[IDX_W-1:0]] <= s_page_addr;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_OVFL)
        else $error("batch count beyond overflow mark");
    a_replay_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (rcnt_reg != '0 && rcnt_reg <= CNT_FULL && idx_reg < rcnt_reg))
        else $error("replay index outside stored batch");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_ready)
        else $error("request taken during replay");
    a_replay_start: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(busy_reg) |-> (count_reg == '0 && idx_reg == '0))
        else $error("replay started without emptying batch");
`endif

endmodule

`default_nettype wire
